FILE: hw/rtl/tfrs_pkg.sv
`default_nettype none
package tfrs_pkg;

  localparam int DEF_NUM_TAGS    = 16;
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int PADDR_W         = 5;
  localparam int EMA_W           = 24;
  localparam int WGT_W           = 16;
  localparam int ACT_W           = 9;
  localparam logic [ACT_W-1:0] CNT_MAX = 9'd511;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  tag_id;
    logic [15:0] op_handle;
    logic        starved;
    logic [15:0] random_value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] granted_handle;
    logic [3:0]  granted_tag;
    logic [8:0]  pending_total;
  } rsp_t;

  typedef enum logic [2:0] {
    CMD_ADMIT      = 3'd0,
    CMD_CONSUME    = 3'd1,
    CMD_FIRST_BYTE = 3'd2,
    CMD_DONE       = 3'd3,
    CMD_TICK       = 3'd4,
    CMD_SHUTDOWN   = 3'd5
  } command_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_GLOBAL_FULL   = 3'd1,
    ST_TAG_FULL      = 3'd2,
    ST_SHUT_DOWN     = 3'd3,
    ST_NONE_ELIGIBLE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_MAX_PENDING_TOTAL   = 3'd0,
    REG_MAX_PENDING_PER_TAG = 3'd1,
    REG_STARVING_CAP        = 3'd2,
    REG_ACTIVE_CAP          = 3'd3,
    REG_EMA_ALPHA           = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [8:0]  max_pending_total;
    logic [4:0]  max_pending_per_tag;
    logic [8:0]  starve_limit;
    logic [8:0]  active_limit;
    logic [15:0] ema_alpha;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SUM, S_TGT, S_SCAN, S_SEL, S_READ, S_POP,
    S_TMUL, S_TADD, S_TDIV, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic acc_clr;
    logic idx_clr;
    logic idx_inc;
    logic idx_pick;
    logic sum_step;
    logic tgt_mul;
    logic scan_step;
    logic pop;
    logic tick_mul;
    logic tick_add;
    logic wgt_write;
    logic set_none;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] command;
    logic       shut;
    logic       alpha_zero;
    logic       idx_last;
    logic       total_zero;
    logic       div_done;
    logic       out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tfrs_ram.sv
`default_nettype none
module tfrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tfrs_div.sv
`default_nettype none
module tfrs_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [24:0] divisor,
  output logic             done,
  output logic      [15:0] quotient
);

  logic [24:0] dvs;
  logic [24:0] rem;
  logic [16:0] q;
  logic [4:0]  cnt;
  logic        run;
  logic [25:0] shifted;
  logic        fits;

  assign shifted  = {rem, 1'b0};
  assign fits     = shifted >= {1'b0, dvs};
  // a zero load gives exactly one, which saturates
  assign quotient = q[16] ? 16'hFFFF : q[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 5'd17;
        dvs <= divisor;
        // upper bits of 2^32 ahead of the 17 quotient bits
        rem <= 25'h8000;
        q   <= '0;
      end else if (run) begin
        rem <= fits ? 25'(shifted - {1'b0, dvs}) : shifted[24:0];
        q   <= {q[15:0], fits};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tfrs_dp.sv
`default_nettype none
module tfrs_dp #(
  parameter int NUM_TAGS    = tfrs_pkg::DEF_NUM_TAGS,
  parameter int QUEUE_DEPTH = tfrs_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tfrs_pkg::req_t     req,
  input  wire tfrs_pkg::cfg_t     cfg,
  input  wire tfrs_pkg::ctrl_cmd_t cmd,
  output tfrs_pkg::dp_stat_t      stat,
  output tfrs_pkg::rsp_t          rsp,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall
);
  import tfrs_pkg::*;

  localparam int TAG_W  = $clog2(NUM_TAGS);
  localparam int HEAD_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W = HEAD_W + 1;
  localparam int STORE  = NUM_TAGS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(STORE);
  localparam int TOT_W  = $clog2(STORE + 1);
  localparam int SUM_W  = WGT_W + $clog2(NUM_TAGS + 1);
  localparam int PROD_W = 16 + SUM_W;

  // request being worked on
  logic [2:0]  cmd_r;
  logic [3:0]  tag_r;
  logic [15:0] handle_r;
  logic        starved_r;
  logic [15:0] rnd_r;

  logic [TAG_W-1:0]  idx;
  logic [HEAD_W-1:0] q_head [NUM_TAGS];
  logic [CNT_W-1:0]  q_count [NUM_TAGS];
  logic [ACT_W-1:0]  act [NUM_TAGS];
  logic [ACT_W-1:0]  stv [NUM_TAGS];
  logic [EMA_W-1:0]  ema [NUM_TAGS];
  logic [WGT_W-1:0]  wgt [NUM_TAGS];
  logic [TOT_W-1:0]  total_pending;
  logic              shut;

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  cum;
  logic              found;
  logic [TAG_W-1:0]  pick;
  logic [EMA_W-1:0]  m1;
  logic [24:0]       m2;

  logic [2:0]  res_status;
  logic [15:0] res_handle;
  logic [3:0]  res_tag;

  logic              elig;
  logic              tag_ok;
  logic [31:0]       lim;
  logic              gl_full;
  logic              tag_full;
  logic              admit_ok;
  logic [SLOT_W-1:0] slot_sum;
  logic [HEAD_W-1:0] slot;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic              ram_we;
  logic [15:0]       ram_rdata;
  logic [SUM_W-1:0]  cum_next;
  logic [SUM_W-1:0]  target;
  logic [16:0]       keep;
  logic [40:0]       decay;
  logic [25:0]       ema_sum;
  logic [EMA_W-1:0]  ema_new;
  logic              div_done;
  logic [15:0]       div_q;

  assign elig = (q_count[idx] != '0) && (stv[idx] < cfg.starve_limit) &&
                (act[idx] < cfg.active_limit);

  assign tag_ok  = 32'(tag_r) < 32'(NUM_TAGS);
  assign lim     = (cfg.max_pending_per_tag == '0 ||
                    32'(cfg.max_pending_per_tag) > 32'(QUEUE_DEPTH)) ?
                   32'(QUEUE_DEPTH) : 32'(cfg.max_pending_per_tag);
  assign gl_full = (cfg.max_pending_total != '0) &&
                   (32'(total_pending) >= 32'(cfg.max_pending_total));
  assign tag_full = !tag_ok || (32'(q_count[idx]) >= lim);
  assign admit_ok = !shut && !gl_full && !tag_full;

  // tail slot wraps around the ring
  assign slot_sum = SLOT_W'(q_head[idx]) + SLOT_W'(q_count[idx]);
  assign slot     = (32'(slot_sum) >= 32'(QUEUE_DEPTH)) ?
                    HEAD_W'(slot_sum - SLOT_W'(QUEUE_DEPTH)) : HEAD_W'(slot_sum);
  assign waddr    = ADDR_W'(32'(idx) * QUEUE_DEPTH + 32'(slot));
  assign raddr    = ADDR_W'(32'(idx) * QUEUE_DEPTH + 32'(q_head[idx]));
  assign ram_we   = cmd.exec && (cmd_r == CMD_ADMIT) && admit_ok;

  tfrs_ram #(
    .WIDTH (16),
    .DEPTH (STORE)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (handle_r),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  assign cum_next = cum + SUM_W'(wgt[idx]);
  assign target   = prod[PROD_W-1:16];

  assign keep    = 17'h10000 - 17'(cfg.ema_alpha);
  assign decay   = 41'(ema[idx]) * 41'(keep);
  assign ema_sum = 26'(m1) + 26'(m2);
  assign ema_new = (ema_sum[25:24] != 2'b00) ? {EMA_W{1'b1}} : ema_sum[23:0];

  tfrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.tick_add),
    .divisor  (25'(ema_new) + 25'h10000),
    .done     (div_done),
    .quotient (div_q)
  );

  assign stat.command    = cmd_r;
  assign stat.shut       = shut;
  assign stat.alpha_zero = (cfg.ema_alpha == '0);
  assign stat.idx_last   = (32'(idx) == 32'(NUM_TAGS - 1));
  assign stat.total_zero = (sum == '0);
  assign stat.div_done   = div_done;
  assign stat.out_busy   = rsp_valid && rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TAGS; i++) begin
        q_head[i]  <= '0;
        q_count[i] <= '0;
        act[i]     <= '0;
        stv[i]     <= '0;
        ema[i]     <= '0;
        wgt[i]     <= 16'hFFFF;
      end
      total_pending <= '0;
      shut          <= 1'b0;
      rsp_valid     <= 1'b0;
      idx           <= '0;
      found         <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
        rsp <= {res_status, res_handle, res_tag, 9'(total_pending)};
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.load) begin
        cmd_r      <= req.command;
        tag_r      <= req.tag_id;
        handle_r   <= req.op_handle;
        starved_r  <= req.starved;
        rnd_r      <= req.random_value;
        idx        <= TAG_W'(req.tag_id);
        res_status <= ST_OK;
        res_handle <= '0;
        res_tag    <= '0;
      end
      if (cmd.idx_clr) idx <= '0;
      if (cmd.idx_inc) idx <= idx + 1'b1;
      if (cmd.idx_pick) idx <= pick;
      if (cmd.acc_clr) sum <= '0;
      if (cmd.sum_step && elig) sum <= sum + SUM_W'(wgt[idx]);
      if (cmd.tgt_mul) begin
        prod  <= PROD_W'(rnd_r) * PROD_W'(sum);
        cum   <= '0;
        found <= 1'b0;
      end
      if (cmd.scan_step && elig && !found) begin
        cum <= cum_next;
        if (target < cum_next) begin
          found <= 1'b1;
          pick  <= idx;
        end
      end
      if (cmd.set_none) res_status <= ST_NONE_ELIGIBLE;
      if (cmd.exec) begin
        unique case (cmd_r)
          CMD_ADMIT: begin
            if (shut) begin
              res_status <= ST_SHUT_DOWN;
            end else if (gl_full) begin
              res_status <= ST_GLOBAL_FULL;
            end else if (tag_full) begin
              res_status <= ST_TAG_FULL;
            end else begin
              q_count[idx]  <= q_count[idx] + 1'b1;
              total_pending <= total_pending + 1'b1;
            end
          end
          CMD_CONSUME: begin
            if (shut) res_status <= ST_SHUT_DOWN;
          end
          CMD_FIRST_BYTE: begin
            if (tag_ok && stv[idx] != '0) stv[idx] <= stv[idx] - 1'b1;
          end
          CMD_DONE: begin
            if (tag_ok) begin
              if (act[idx] != '0) act[idx] <= act[idx] - 1'b1;
              if (starved_r && stv[idx] != '0) stv[idx] <= stv[idx] - 1'b1;
            end
          end
          CMD_SHUTDOWN: shut <= 1'b1;
          default: ;
        endcase
      end
      if (cmd.pop) begin
        res_handle    <= ram_rdata;
        res_tag       <= 4'(idx);
        q_head[idx]   <= (32'(q_head[idx]) == 32'(QUEUE_DEPTH - 1)) ?
                         '0 : q_head[idx] + 1'b1;
        q_count[idx]  <= q_count[idx] - 1'b1;
        total_pending <= total_pending - 1'b1;
        if (act[idx] != CNT_MAX) act[idx] <= act[idx] + 1'b1;
        if (stv[idx] != CNT_MAX) stv[idx] <= stv[idx] + 1'b1;
      end
      if (cmd.tick_mul) begin
        m1 <= decay[39:16];
        m2 <= 25'(cfg.ema_alpha) * 25'(act[idx]);
      end
      if (cmd.tick_add) ema[idx] <= ema_new;
      if (cmd.wgt_write) wgt[idx] <= div_q;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> q_count[idx] != '0)
    else $error("pop from an empty tag queue");

  a_pick_found: assert property (@(posedge clk) disable iff (rst)
    cmd.idx_pick |-> found)
    else $error("weighted scan ended without a pick");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> 32'(q_count[idx]) < 32'(QUEUE_DEPTH) && tag_ok)
    else $error("queue write beyond its depth");

endmodule
`default_nettype wire

FILE: hw/rtl/tfrs_ctrl.sv
`default_nettype none
module tfrs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire tfrs_pkg::dp_stat_t stat,
  output tfrs_pkg::ctrl_cmd_t     cmd
);
  import tfrs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_DONE;
        if (stat.command == CMD_CONSUME && !stat.shut) begin
          cmd.acc_clr = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = S_SUM;
        end else if (stat.command == CMD_TICK && !stat.alpha_zero) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_TMUL;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (stat.idx_last) begin
          state_next = S_TGT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_TGT: begin
        if (stat.total_zero) begin
          cmd.set_none = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.tgt_mul = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.idx_last) begin
          state_next = S_SEL;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SEL: begin
        cmd.idx_pick = 1'b1;
        state_next   = S_READ;
      end
      // queue memory read is registered
      S_READ: state_next = S_POP;
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_DONE;
      end
      S_TMUL: begin
        cmd.tick_mul = 1'b1;
        state_next   = S_TADD;
      end
      S_TADD: begin
        cmd.tick_add = 1'b1;
        state_next   = S_TDIV;
      end
      S_TDIV: begin
        if (stat.div_done) begin
          cmd.wgt_write = 1'b1;
          if (stat.idx_last) begin
            state_next = S_DONE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_TMUL;
          end
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tag_fair_request_scheduler.sv
`default_nettype none
// channel   direction  handshake              payload
// request   in         req_valid / req_stall  req (command, tag, handle, flags, random)
// response  out        rsp_valid / rsp_stall  rsp (status, handle, tag, pending total)
// config    in         psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// admit, first byte, done, shutdown: load, execute, then respond before the next request is taken
// consume: a summing scan and a picking scan over the tags, one tag a cycle (no pick scan if none is eligible)
// tick: per tag an EMA multiply, an add and the 17-step weight divider, skipped when alpha is zero
// reset initialises all per-tag state; queue storage is not cleared
// a response held by rsp_stall sits in its own register while the next request runs
module tag_fair_request_scheduler #(
  parameter int NUM_TAGS    = tfrs_pkg::DEF_NUM_TAGS,
  parameter int QUEUE_DEPTH = tfrs_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire tfrs_pkg::req_t               req,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output tfrs_pkg::rsp_t                    rsp,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tfrs_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);
  import tfrs_pkg::*;

  cfg_t       cfg;
  reg_index_t reg_sel;
  ctrl_cmd_t  cmd;
  dp_stat_t   stat;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_pending_total   <= '0;
      cfg.max_pending_per_tag <= '0;
      cfg.starve_limit        <= 9'd256;
      cfg.active_limit        <= 9'd256;
      cfg.ema_alpha           <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_MAX_PENDING_TOTAL:   cfg.max_pending_total   <= pwdata[8:0];
        REG_MAX_PENDING_PER_TAG: cfg.max_pending_per_tag <= pwdata[4:0];
        REG_STARVING_CAP:        cfg.starve_limit        <= pwdata[8:0];
        REG_ACTIVE_CAP:          cfg.active_limit        <= pwdata[8:0];
        REG_EMA_ALPHA:           cfg.ema_alpha           <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAX_PENDING_TOTAL:   prdata = 32'(cfg.max_pending_total);
      REG_MAX_PENDING_PER_TAG: prdata = 32'(cfg.max_pending_per_tag);
      REG_STARVING_CAP:        prdata = 32'(cfg.starve_limit);
      REG_ACTIVE_CAP:          prdata = 32'(cfg.active_limit);
      REG_EMA_ALPHA:           prdata = 32'(cfg.ema_alpha);
      default:                 prdata = '0;
    endcase
  end

  tfrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tfrs_dp #(
    .NUM_TAGS    (NUM_TAGS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

endmodule
`default_nettype wire
